[sv/tes_pkg.sv]
// Package for the timed event scheduler: payload structs, controller/datapath
// command and status structs, and shared constants. No dependencies.
package tes_pkg;

   localparam int EVENT_SLOTS_DEF = 64;
   localparam int TIME_W          = 52;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [7:0]  CLOSE_DELAY_RST = 8'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [1:0] MSEL_NOW   = 2'd0;
   localparam logic [1:0] MSEL_OPEN  = 2'd1;
   localparam logic [1:0] MSEL_CLOSE = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [31:0] now_s;
      logic [19:0] now_us;
      logic [31:0] delay_s;
   } req_payload_type;

   typedef struct packed {
      logic        opened;
      logic        closed;
      logic [51:0] open_alarm_us;
      logic [51:0] close_alarm_us;
      logic [6:0]  entry_count;
      logic [1:0]  add_status;
   } rsp_payload_type;

   typedef struct packed {
      logic       accept;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       fire;
      logic       scan_start;
      logic       scan_issue;
      logic       commit;
      logic       close_chk;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic is_add;
      logic open_due;
      logic addr_last;
      logic scan_busy;
      logic out_free;
   } sts_type;

endpackage

[sv/tes_ctrl.sv]
// Controller for the timed event scheduler: sequences multiply, table scan,
// commit, close check and result load. Depends on tes_pkg.
module tes_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tes_pkg::sts_type sts,
   output tes_pkg::cmd_type cmd
);
   import tes_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_TCHK   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_COMMIT = 3'd5;
   localparam logic [2:0] S_CLOSE  = 3'd6;
   localparam logic [2:0] S_FIN    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] msel_ff, msel_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      msel_in  = msel_ff;
      cmd      = '0;
      cmd.mul_sel = msel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               msel_in    = MSEL_NOW;
               state_in   = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            if (!sts.is_add) begin
               state_in = S_TCHK;
            end else if (msel_ff == MSEL_CLOSE) begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               msel_in = msel_ff + 2'd1;
            end
         end
         S_TCHK: begin
            if (sts.open_due) begin
               cmd.fire       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_CLOSE;
            end
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.addr_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.scan_busy) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.is_add ? S_FIN : S_CLOSE;
         end
         S_CLOSE: begin
            cmd.close_chk = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         msel_ff  <= MSEL_NOW;
      end else begin
         state_ff <= state_in;
         msel_ff  <= msel_in;
      end
   end

endmodule

[sv/tes_dp.sv]
// Datapath for the timed event scheduler: time conversion, event table memory,
// scan pipeline, alarm registers and result register. Depends on tes_pkg.
module tes_dp #(
   parameter int EVENT_SLOTS = tes_pkg::EVENT_SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tes_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tes_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data,
   input  tes_pkg::cmd_type         cmd,
   output tes_pkg::sts_type         sts
);
   import tes_pkg::*;

   localparam int IDX_W = $clog2(EVENT_SLOTS);
   localparam int CNT_W = $clog2(EVENT_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EVENT_SLOTS - 1);

   logic [TIME_W-1:0] mem_open  [EVENT_SLOTS];
   logic [TIME_W-1:0] mem_close [EVENT_SLOTS];
   logic [EVENT_SLOTS-1:0] valid_ff;

   logic [7:0]  cd_ff;
   logic        mode_ff;
   logic [31:0] now_s_ff, open_s_ff, close_s_ff;
   logic [19:0] now_us_ff;
   logic [TIME_W-1:0] now_t_ff, op_t_ff, cl_t_ff;
   logic [TIME_W-1:0] pend_open_ff, pend_close_ff, ca_time_ff;
   logic        ca_armed_ff;
   logic [CNT_W-1:0] count_ff;

   logic [IDX_W-1:0] addr_ff, p_idx_ff, free_idx_ff;
   logic        p_vld_ff;
   logic [TIME_W-1:0] rd_open_ff, rd_close_ff, best_open_ff, best_close_ff;
   logic        dup_ff, free_found_ff, best_found_ff;
   logic        opened_ff, closed_ff;
   logic [1:0]  status_ff;
   logic        rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // shared converter: seconds * 1e6 + micro
   logic [31:0] mul_s;
   logic [TIME_W-1:0] mul_res;
   always_comb begin
      case (cmd.mul_sel)
         MSEL_OPEN:  mul_s = open_s_ff;
         MSEL_CLOSE: mul_s = close_s_ff;
         default:    mul_s = now_s_ff;
      endcase
   end
   assign mul_res = TIME_W'(mul_s) * TIME_W'(USEC_PER_SEC) + TIME_W'(now_us_ff);

   // scan data stage
   logic cur_v, cur_dup, cur_free, cur_gone, cur_cand;
   assign cur_v    = p_vld_ff && valid_ff[p_idx_ff];
   assign cur_dup  = mode_ff == MODE_ADD && cur_v && rd_open_ff == op_t_ff;
   assign cur_free = mode_ff == MODE_ADD && p_vld_ff && !valid_ff[p_idx_ff] && !free_found_ff;
   assign cur_gone = mode_ff == MODE_TICK && cur_v && rd_open_ff <= now_t_ff;
   assign cur_cand = cur_v && !cur_gone &&
                     (!best_found_ff || rd_open_ff < best_open_ff);

   // refresh candidate at commit
   logic insert, c_found;
   logic [TIME_W-1:0] c_open, c_close;
   always_comb begin
      insert  = mode_ff == MODE_ADD && !dup_ff && free_found_ff;
      c_found = best_found_ff;
      c_open  = best_open_ff;
      c_close = best_close_ff;
      if (insert && (!best_found_ff || op_t_ff < best_open_ff)) begin
         c_found = 1'b1;
         c_open  = op_t_ff;
         c_close = cl_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_vld_ff || cmd.scan_issue) begin
         rd_open_ff  <= mem_open[addr_ff];
         rd_close_ff <= mem_close[addr_ff];
      end
      if (cmd.commit && insert) begin
         mem_open[free_idx_ff]  <= op_t_ff;
         mem_close[free_idx_ff] <= cl_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff    <= req_payload.mode;
         now_s_ff   <= req_payload.now_s;
         now_us_ff  <= req_payload.now_us;
         open_s_ff  <= req_payload.now_s + req_payload.delay_s;
         close_s_ff <= req_payload.now_s + req_payload.delay_s + 32'(cd_ff);
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_OPEN:  op_t_ff  <= mul_res;
            MSEL_CLOSE: cl_t_ff  <= mul_res;
            default:    now_t_ff <= mul_res;
         endcase
      end
      p_idx_ff <= addr_ff;
      if (cur_cand) begin
         best_open_ff  <= rd_open_ff;
         best_close_ff <= rd_close_ff;
      end
      if (cur_free) begin
         free_idx_ff <= p_idx_ff;
      end
      if (cmd.load_out) begin
         rsp_payload_ff.opened         <= opened_ff;
         rsp_payload_ff.closed         <= closed_ff;
         rsp_payload_ff.open_alarm_us  <= pend_open_ff;
         rsp_payload_ff.close_alarm_us <= pend_close_ff;
         rsp_payload_ff.entry_count    <= 7'(count_ff);
         rsp_payload_ff.add_status     <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_ff         <= CLOSE_DELAY_RST;
         valid_ff      <= '0;
         pend_open_ff  <= '0;
         pend_close_ff <= '0;
         ca_armed_ff   <= 1'b0;
         ca_time_ff    <= '0;
         count_ff      <= '0;
         addr_ff       <= '0;
         p_vld_ff      <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         best_found_ff <= 1'b0;
         opened_ff     <= 1'b0;
         closed_ff     <= 1'b0;
         status_ff     <= ST_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cd_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            opened_ff <= 1'b0;
            closed_ff <= 1'b0;
            status_ff <= ST_OK;
         end
         if (cmd.fire) begin
            opened_ff    <= 1'b1;
            pend_open_ff <= '0;
            ca_armed_ff  <= 1'b1;
            ca_time_ff   <= pend_close_ff;
         end
         // scan pipeline
         p_vld_ff <= cmd.scan_issue;
         if (cmd.scan_start) begin
            addr_ff       <= '0;
            dup_ff        <= 1'b0;
            free_found_ff <= 1'b0;
            best_found_ff <= 1'b0;
         end else if (cmd.scan_issue && addr_ff != LAST_IDX) begin
            addr_ff <= addr_ff + IDX_W'(1);
         end
         if (cur_dup)  dup_ff        <= 1'b1;
         if (cur_free) free_found_ff <= 1'b1;
         if (cur_cand) best_found_ff <= 1'b1;
         if (cur_gone) begin
            valid_ff[p_idx_ff] <= 1'b0;
            count_ff           <= count_ff - CNT_W'(1);
         end
         if (cmd.commit) begin
            if (mode_ff == MODE_ADD) begin
               if (dup_ff) begin
                  status_ff <= ST_DUP;
               end else if (!free_found_ff) begin
                  status_ff <= ST_FULL;
               end else begin
                  valid_ff[free_idx_ff] <= 1'b1;
                  count_ff              <= count_ff + CNT_W'(1);
               end
            end
            if (c_found && c_open > now_t_ff && c_open != pend_open_ff) begin
               if (pend_close_ff == '0 || c_close > pend_close_ff ||
                   c_open < pend_open_ff) begin
                  pend_close_ff <= c_close;
               end
               pend_open_ff <= c_open;
            end
         end
         if (cmd.close_chk && ca_armed_ff && ca_time_ff <= now_t_ff) begin
            closed_ff   <= 1'b1;
            ca_armed_ff <= 1'b0;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.is_add    = (mode_ff == MODE_ADD);
   assign sts.open_due  = pend_open_ff != '0 && pend_open_ff <= now_t_ff;
   assign sts.addr_last = (addr_ff == LAST_IDX);
   assign sts.scan_busy = p_vld_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[sv/timed_event_scheduler.sv]
// Timed event scheduler. An add converts its times, scans the table and commits; a tick
// fires any due open alarm with a scan and commit, then checks close. One item at a time;
// each add, and each tick that fires, scans all slots with one memory read per cycle.
// Reset (synchronous, active high) empties the table, clears alarms and sets
// close_delay_s to 3; no clearing pass is needed since slot valid bits are flops.
module timed_event_scheduler #(
   parameter int EVENT_SLOTS = tes_pkg::EVENT_SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tes_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tes_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [7:0]               csr_wr_data
);
   import tes_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller: accepts a beat, walks convert -> [scan -> commit] -> [close] -> result.
   tes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: event table, min/dup/free scan, alarm state and result register.
   tes_dp #(
      .EVENT_SLOTS (EVENT_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

[sv/tes_checker.sv]
// Port-level checker for the timed event scheduler, bound to the top level.
// Depends on tes_pkg.
module tes_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input tes_pkg::rsp_payload_type rsp_payload
);
   import tes_pkg::*;

   a_rst_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.add_status != 2'd3)
      else $error("bad add status");

   a_alarm_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.opened || rsp_payload.closed) |->
         rsp_payload.add_status == ST_OK)
      else $error("alarm fired on an add beat");

endmodule

bind timed_event_scheduler tes_checker u_tes_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
